[hdl/tcce_pkg.sv]
package tcce_pkg;

   localparam logic [7:0] CH_BS      = 8'd8;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] RESET_ATTR = 8'd7;

   typedef enum logic [1:0] {
      ACT_PUT   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_PRINT,
      KIND_BS,
      KIND_TAB,
      KIND_LF,
      KIND_CR
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRE,
      ST_SCROLL,
      ST_ACT,
      ST_READ,
      ST_RDCAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic wrap;
      logic scroll_start;
      logic clear_start;
      logic sweep_step;
      logic put;
      logic put_space;
      logic bs;
      logic lf;
      logic col0;
      logic read_issue;
      logic read_capture;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     wrap_pend;
      logic     last_row;
      logic     tab_last;
      logic     row_swept;
      logic     all_swept;
      logic     out_busy;
   } status_type;

endpackage

[hdl/tcce_ctrl.sv]
module tcce_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  tcce_pkg::action_type   req_action,
   output logic                   req_stall,
   input  tcce_pkg::status_type   sts,
   output tcce_pkg::cmd_type      cmd
);

   tcce_pkg::state_type state_ff, state_in;
   logic                tab_ff, tab_in;
   logic                ret_act_ff, ret_act_in;
   logic                item_ff, item_in;
   tcce_pkg::kind_type  kind_eff;

   // tab expands into a run of plain spaces
   assign kind_eff = tab_ff ? tcce_pkg::KIND_PRINT : sts.kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tcce_pkg::ST_CLEAR;
         tab_ff     <= 1'b0;
         ret_act_ff <= 1'b0;
         item_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tab_ff     <= tab_in;
         ret_act_ff <= ret_act_in;
         item_ff    <= item_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      tab_in     = tab_ff;
      ret_act_in = ret_act_ff;
      item_in    = item_ff;
      unique case (state_ff)
         tcce_pkg::ST_CLEAR: begin
            if (sts.all_swept) begin
               state_in = item_ff ? tcce_pkg::ST_DONE : tcce_pkg::ST_IDLE;
               item_in  = 1'b0;
            end
         end
         tcce_pkg::ST_IDLE: begin
            if (req_valid) begin
               tab_in = 1'b0;
               unique case (req_action)
                  tcce_pkg::ACT_PUT:   state_in = tcce_pkg::ST_PRE;
                  tcce_pkg::ACT_READ:  state_in = tcce_pkg::ST_READ;
                  tcce_pkg::ACT_CLEAR: begin
                     state_in = tcce_pkg::ST_CLEAR;
                     item_in  = 1'b1;
                  end
                  tcce_pkg::ACT_NOP:   state_in = tcce_pkg::ST_DONE;
               endcase
            end
         end
         tcce_pkg::ST_PRE: begin
            if (sts.wrap_pend && (kind_eff != tcce_pkg::KIND_LF) && sts.last_row) begin
               ret_act_in = 1'b1;
               state_in   = tcce_pkg::ST_SCROLL;
            end else begin
               state_in = tcce_pkg::ST_ACT;
            end
         end
         tcce_pkg::ST_SCROLL: begin
            if (sts.row_swept) begin
               state_in = ret_act_ff ? tcce_pkg::ST_ACT : tcce_pkg::ST_DONE;
            end
         end
         tcce_pkg::ST_ACT: begin
            unique case (kind_eff)
               tcce_pkg::KIND_PRINT: begin
                  state_in = (tab_ff && !sts.tab_last) ? tcce_pkg::ST_PRE
                                                       : tcce_pkg::ST_DONE;
               end
               tcce_pkg::KIND_TAB: begin
                  tab_in   = 1'b1;
                  state_in = tcce_pkg::ST_PRE;
               end
               tcce_pkg::KIND_LF: begin
                  if (sts.last_row) begin
                     ret_act_in = 1'b0;
                     state_in   = tcce_pkg::ST_SCROLL;
                  end else begin
                     state_in = tcce_pkg::ST_DONE;
                  end
               end
               default: state_in = tcce_pkg::ST_DONE;
            endcase
         end
         tcce_pkg::ST_READ:  state_in = tcce_pkg::ST_RDCAP;
         tcce_pkg::ST_RDCAP: state_in = tcce_pkg::ST_DONE;
         tcce_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               state_in = tcce_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tcce_pkg::ST_CLEAR:  cmd.sweep_step = 1'b1;
         tcce_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept      = 1'b1;
               cmd.clear_start = (req_action == tcce_pkg::ACT_CLEAR);
            end
         end
         tcce_pkg::ST_PRE: begin
            if (sts.wrap_pend && (kind_eff != tcce_pkg::KIND_LF)) begin
               cmd.wrap         = 1'b1;
               cmd.scroll_start = sts.last_row;
            end
         end
         tcce_pkg::ST_SCROLL: cmd.sweep_step = 1'b1;
         tcce_pkg::ST_ACT: begin
            unique case (kind_eff)
               tcce_pkg::KIND_PRINT: begin
                  cmd.put       = 1'b1;
                  cmd.put_space = tab_ff;
               end
               tcce_pkg::KIND_BS: cmd.bs = 1'b1;
               tcce_pkg::KIND_LF: begin
                  cmd.lf           = 1'b1;
                  cmd.scroll_start = sts.last_row;
               end
               tcce_pkg::KIND_CR: cmd.col0 = 1'b1;
               default: ;
            endcase
         end
         tcce_pkg::ST_READ:  cmd.read_issue   = 1'b1;
         tcce_pkg::ST_RDCAP: cmd.read_capture = 1'b1;
         tcce_pkg::ST_DONE:  cmd.rsp_load     = !sts.out_busy;
      endcase
   end

endmodule

[hdl/tcce_dp.sv]
module tcce_dp #(
   parameter int COLS     = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_char_code,
   input  logic [7:0]            req_attribute,
   input  logic [4:0]            req_read_row,
   input  logic [6:0]            req_read_col,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [15:0]           rsp_cell_value,
   output logic [4:0]            rsp_cursor_row,
   output logic [6:0]            rsp_cursor_col,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  tcce_pkg::cmd_type     cmd,
   output tcce_pkg::status_type  sts
);

   localparam int ROW_W  = $clog2(ROWS);
   localparam int SUM_W  = ROW_W + 1;
   localparam int COL_W  = $clog2(COLS + 1);
   localparam int SCOL_W = $clog2(COLS);
   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

   logic [15:0]        cell_ram [DEPTH];
   logic [15:0]        rd_data_ff;

   logic [7:0]         csr_attr_ff, csr_attr_in;
   logic [7:0]         fill_attr_ff, fill_attr_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [PH_W-1:0]    tab_ph_ff, tab_ph_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [ROW_W-1:0]   swp_row_ff, swp_row_in;
   logic [SCOL_W-1:0]  swp_col_ff, swp_col_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [7:0]         char_ff;
   logic [7:0]         attr_ff;
   logic [4:0]         rd_row_ff;
   logic [6:0]         rd_col_ff;
   logic [15:0]        cell_ff;
   logic [15:0]        rsp_cell_ff;
   logic [4:0]         rsp_row_ff;
   logic [6:0]         rsp_col_ff;

   logic               last_row;
   logic               last_top;
   logic               ph_last;
   logic               col_zero;
   logic [SCOL_W-1:0]  cur_col_s;
   logic [SCOL_W-1:0]  bs_col;
   logic               read_ok;
   logic               wr_en;
   logic [ROW_W-1:0]   wr_row;
   logic [SCOL_W-1:0]  wr_col;
   logic [ADDR_W-1:0]  wr_addr;
   logic [15:0]        wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   tcce_pkg::kind_type kind;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                  input logic [ROW_W-1:0] top);
      logic [SUM_W-1:0] s;
      s = {1'b0, lr} + {1'b0, top};
      if (s >= SUM_W'(ROWS)) begin
         s = s - SUM_W'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0]  row,
                                                   input logic [SCOL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
   endfunction

   always_comb begin
      unique case (char_ff)
         tcce_pkg::CH_BS:  kind = tcce_pkg::KIND_BS;
         tcce_pkg::CH_TAB: kind = tcce_pkg::KIND_TAB;
         tcce_pkg::CH_LF:  kind = tcce_pkg::KIND_LF;
         tcce_pkg::CH_CR:  kind = tcce_pkg::KIND_CR;
         default:          kind = tcce_pkg::KIND_PRINT;
      endcase
   end

   assign last_row  = (cur_row_ff == ROW_W'(ROWS - 1));
   assign last_top  = (top_ff == ROW_W'(ROWS - 1));
   assign ph_last   = (tab_ph_ff == PH_W'(TAB_STOP - 1));
   assign col_zero  = (cur_col_ff == '0);
   assign cur_col_s = SCOL_W'(cur_col_ff);
   assign bs_col    = col_zero ? '0 : cur_col_s - SCOL_W'(1);
   assign read_ok   = (32'(rd_row_ff) < ROWS) && (32'(rd_col_ff) < COLS);

   assign sts.kind      = kind;
   assign sts.wrap_pend = (cur_col_ff == COL_W'(COLS));
   assign sts.last_row  = last_row;
   assign sts.tab_last  = ph_last;
   assign sts.row_swept = (swp_col_ff == SCOL_W'(COLS - 1));
   assign sts.all_swept = sts.row_swept && (swp_row_ff == ROW_W'(ROWS - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   // single write port: blanking sweep, a character at the cursor, or a backspace blank left of it
   always_comb begin
      wr_en   = cmd.sweep_step || cmd.put || cmd.bs;
      wr_row  = phys_row(cur_row_ff, top_ff);
      wr_col  = cmd.bs ? bs_col : cur_col_s;
      wr_data = {attr_ff, tcce_pkg::CH_SPACE};
      if (cmd.sweep_step) begin
         wr_row  = swp_row_ff;
         wr_col  = swp_col_ff;
         wr_data = {fill_attr_ff, tcce_pkg::CH_SPACE};
      end else if (cmd.put && !cmd.put_space) begin
         wr_data = {attr_ff, char_ff};
      end
   end

   assign wr_addr = cell_addr(wr_row, wr_col);
   assign rd_addr = cell_addr(phys_row(ROW_W'(rd_row_ff), top_ff), SCOL_W'(rd_col_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue && read_ok) begin
         rd_data_ff <= cell_ram[rd_addr];
      end
   end

   always_comb begin
      csr_attr_in  = csr_wr_en ? csr_wr_data : csr_attr_ff;
      fill_attr_in = fill_attr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      tab_ph_in    = tab_ph_ff;
      top_in       = top_ff;
      swp_row_in   = swp_row_ff;
      swp_col_in   = swp_col_ff;

      if (cmd.sweep_step) begin
         if (sts.row_swept) begin
            swp_col_in = '0;
            swp_row_in = (swp_row_ff == ROW_W'(ROWS - 1)) ? '0 : swp_row_ff + ROW_W'(1);
         end else begin
            swp_col_in = swp_col_ff + SCOL_W'(1);
         end
      end

      // the oldest row becomes the new bottom row
      if (cmd.scroll_start) begin
         fill_attr_in = csr_attr_ff;
         swp_row_in   = top_ff;
         swp_col_in   = '0;
         top_in       = last_top ? '0 : top_ff + ROW_W'(1);
      end

      if (cmd.wrap || cmd.lf) begin
         cur_col_in = '0;
         tab_ph_in  = '0;
         if (!last_row) begin
            cur_row_in = cur_row_ff + ROW_W'(1);
         end
      end

      if (cmd.col0) begin
         cur_col_in = '0;
         tab_ph_in  = '0;
      end

      if (cmd.put) begin
         cur_col_in = cur_col_ff + COL_W'(1);
         tab_ph_in  = ph_last ? '0 : tab_ph_ff + PH_W'(1);
      end

      if (cmd.bs && !col_zero) begin
         cur_col_in = cur_col_ff - COL_W'(1);
         tab_ph_in  = (tab_ph_ff == '0) ? PH_W'(TAB_STOP - 1) : tab_ph_ff - PH_W'(1);
      end

      if (cmd.clear_start) begin
         fill_attr_in = csr_attr_ff;
         swp_row_in   = '0;
         swp_col_in   = '0;
         top_in       = '0;
         cur_row_in   = '0;
         cur_col_in   = '0;
         tab_ph_in    = '0;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_attr_ff  <= tcce_pkg::RESET_ATTR;
         fill_attr_ff <= tcce_pkg::RESET_ATTR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         tab_ph_ff    <= '0;
         top_ff       <= '0;
         swp_row_ff   <= '0;
         swp_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_attr_ff  <= csr_attr_in;
         fill_attr_ff <= fill_attr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         tab_ph_ff    <= tab_ph_in;
         top_ff       <= top_in;
         swp_row_ff   <= swp_row_in;
         swp_col_ff   <= swp_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff   <= req_char_code;
         attr_ff   <= req_attribute;
         rd_row_ff <= req_read_row;
         rd_col_ff <= req_read_col;
         cell_ff   <= '0;
      end else if (cmd.read_capture) begin
         cell_ff <= read_ok ? rd_data_ff : '0;
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= cell_ff;
         rsp_row_ff  <= 5'(cur_row_ff);
         rsp_col_ff  <= 7'(cur_col_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;

endmodule

[hdl/text_console_cursor_engine.sv]
// Text console engine: a ROWS x COLS screen of 16-bit cells (attribute high byte,
// character low byte) in one single-port-write RAM, plus a cursor. Rows are kept
// as a ring, so a scroll only moves the top-row pointer and blanks one row,
// one cell per cycle. A word is accepted only in the idle state, and the next
// word is stalled until the result of the last one is loaded into the output
// register. A put, tab or line feed may scroll the screen; a tab puts spaces up
// to the next stop, up to TAB_STOP spaces; a clear blanks all ROWS*COLS cells
// and homes the cursor. After reset the RAM is blanked in a sweep over all
// ROWS*COLS cells (2000 at the default size) before the first word is accepted;
// the register port is live throughout. A finished result sits in an output
// register, and the next word is accepted while it waits.
module text_console_cursor_engine #(
   parameter int COLS     = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_attribute,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cell_value,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tcce_pkg::cmd_type    cmd;
   tcce_pkg::status_type sts;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (tcce_pkg::action_type'(req_action)),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcce_dp #(
      .COLS     (COLS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_char_code  (req_char_code),
      .req_attribute  (req_attribute),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
